@@ src/ss1kd_pkg.sv @@
// Shared types, codes and lookup functions for the set-1 scan code decoder.
package ss1kd_pkg;

    localparam int ByteW   = 8;
    localparam int KindW   = 2;
    localparam int ModW    = 8;
    localparam int LockW   = 3;
    localparam int ActW    = 4;
    localparam int PfxW    = 2;
    localparam int OutW    = 32;

    // Prefix tracker codes
    localparam logic [PfxW-1:0] PFX_IDLE = 2'd0;
    localparam logic [PfxW-1:0] PFX_E0   = 2'd1;
    localparam logic [PfxW-1:0] PFX_E1A  = 2'd2;
    localparam logic [PfxW-1:0] PFX_E1B  = 2'd3;

    // Event kinds
    localparam logic [KindW-1:0] KIND_KEY     = 2'd0;
    localparam logic [KindW-1:0] KIND_REBOOT  = 2'd1;
    localparam logic [KindW-1:0] KIND_CONSOLE = 2'd2;

    localparam logic [ByteW-1:0] BYTE_E0      = 8'hE0;
    localparam logic [ByteW-1:0] BYTE_E1      = 8'hE1;
    localparam logic [6:0]       CODE_CTRL    = 7'h1D;
    localparam logic [6:0]       CODE_NUMLK   = 7'h45;
    localparam logic [6:0]       CODE_HOLE    = 7'h55;
    localparam logic [6:0]       CODE_MAX     = 7'h58;

    localparam logic [ByteW-1:0] ID_NONE      = 8'h00;
    localparam logic [ByteW-1:0] ID_PAUSE     = 8'hC5;
    localparam logic [ByteW-1:0] ID_DELETE    = 8'hD3;
    localparam logic [ByteW-1:0] ID_PADDELETE = 8'h53;
    localparam logic [ByteW-1:0] ID_NUMLOCK   = 8'h45;
    localparam logic [ByteW-1:0] ID_CAPSLOCK  = 8'h3A;
    localparam logic [ByteW-1:0] ID_SCROLL    = 8'h46;

    localparam logic [LockW-1:0] LOCK_SCROLL  = 3'h1;
    localparam logic [LockW-1:0] LOCK_NUM     = 3'h2;
    localparam logic [LockW-1:0] LOCK_CAPS    = 3'h4;
    localparam logic [LockW-1:0] LOCK_RESET   = LOCK_NUM;

    localparam logic [ModW-1:0]  MOD_CTRL_ANY = 8'h11;
    localparam logic [ModW-1:0]  MOD_ALT_ANY  = 8'h44;

    localparam logic [ActW-1:0]  ACT_NONE     = 4'd0;
    localparam logic [ActW-1:0]  ACT_DELETE   = 4'd1;
    localparam logic [ActW-1:0]  ACT_PADDEL   = 4'd2;

    typedef struct packed {
        logic [PfxW-1:0]  prefix;
        logic [ModW-1:0]  mods;
        logic [LockW-1:0] locks;
    } dec_state_t;

    typedef struct packed {
        logic             valid;
        logic [KindW-1:0] event_kind;
        logic [ByteW-1:0] key_id;
        logic             released;
        logic [ModW-1:0]  modifiers;
        logic [LockW-1:0] lock_leds;
        logic             leds_changed;
        logic [ActW-1:0]  action_value;
    } dec_result_t;

    // Key id for the byte after E0, or ID_NONE when unlisted
    function automatic logic [ByteW-1:0] ext_id(input logic [6:0] c);
        logic [ByteW-1:0] id;
        unique case (c)
            7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D,
            7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C: id = {1'b1, c};
            7'h37:   id = 8'h54;
            7'h46:   id = ID_PAUSE;
            default: id = ID_NONE;
        endcase
        return id;
    endfunction

    function automatic logic [ModW-1:0] mod_bit(input logic [ByteW-1:0] id);
        logic [ModW-1:0] m;
        unique case (id)
            8'h1D:   m = 8'h01;
            8'h2A:   m = 8'h02;
            8'h38:   m = 8'h04;
            8'hDB:   m = 8'h08;
            8'h9D:   m = 8'h10;
            8'h36:   m = 8'h20;
            8'hB8:   m = 8'h40;
            8'hDC:   m = 8'h80;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Function key number 1..12, 0 for other keys
    function automatic logic [ActW-1:0] fkey_num(input logic [ByteW-1:0] id);
        logic [ActW-1:0] f;
        unique case (id)
            8'h3B: f = 4'd1;
            8'h3C: f = 4'd2;
            8'h3D: f = 4'd3;
            8'h3E: f = 4'd4;
            8'h3F: f = 4'd5;
            8'h40: f = 4'd6;
            8'h41: f = 4'd7;
            8'h42: f = 4'd8;
            8'h43: f = 4'd9;
            8'h44: f = 4'd10;
            8'h57: f = 4'd11;
            8'h58: f = 4'd12;
            default: f = ACT_NONE;
        endcase
        return f;
    endfunction

endpackage

@@ src/scan_set1_key_decoder.sv @@
// Top level: input register, decoder state, and result register on stream ports.
// A byte is held in the input register until the result register is free, then decoded into it.
// Throughput: one byte per cycle unless m_tready stalls; the state update in ss1kd_decode is combinational.
// Bytes that cause no result (prefixes, unknown codes, chord releases) are dropped.
// Reset (aresetn low, synchronous): prefix idle, modifiers clear, Num Lock LED on,
// both pipeline stages empty.
module scan_set1_key_decoder
    import ss1kd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] scan_byte
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [OutW-1:0] m_tdata    // [1:0] event_kind, [9:2] key_id, [10] released,
                                       // [18:11] modifiers, [21:19] lock_leds,
                                       // [22] leds_changed, [26:23] action_value, [31:27] 0
);

    logic             in_valid_reg, in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    dec_result_t      out_reg;
    dec_state_t       state_reg;
    dec_state_t       state_next;
    dec_result_t      res;
    logic             advance;

    ss1kd_decode u_decode (
        .scan_byte (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res)
    );

    // Move a byte through decode when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.prefix <= PFX_IDLE;
            state_reg.mods   <= '0;
            state_reg.locks  <= LOCK_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.action_value, out_reg.leds_changed, out_reg.lock_leds,
                       out_reg.modifiers, out_reg.released, out_reg.key_id,
                       out_reg.event_kind};

    a_reset_locks: assert property (@(posedge aclk)
        !aresetn |=> (state_reg.locks == LOCK_RESET && state_reg.prefix == PFX_IDLE))
        else $error("lock or prefix state wrong after reset");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("decoder state changed without a byte");

    a_e1b_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && state_next.prefix == PFX_E1B) |-> state_reg.prefix == PFX_E1A)
        else $error("second Pause stage entered without E1");

    a_led_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.leds_changed) |->
        (out_reg.event_kind == KIND_KEY && !out_reg.released))
        else $error("LED change flagged on a non-press event");

    a_action_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.event_kind == KIND_KEY) |-> out_reg.action_value == ACT_NONE)
        else $error("action value on plain key event");

endmodule

@@ src/ss1kd_decode.sv @@
// Combinational byte decoder: prefix tracking, key mapping, flag update and event build.
module ss1kd_decode
    import ss1kd_pkg::*;
(
    input  logic [ByteW-1:0] scan_byte,
    input  dec_state_t       cur,
    output dec_state_t       nxt,
    output dec_result_t      res
);

    always_comb begin
        logic             rel;
        logic [6:0]       c;
        logic [ByteW-1:0] id;
        logic [ModW-1:0]  m;
        logic [LockW-1:0] lock;
        logic             changed;
        logic [ActW-1:0]  f;
        logic             chord;

        rel     = scan_byte[7];
        c       = scan_byte[6:0];
        id      = ID_NONE;
        nxt     = cur;
        changed = 1'b0;
        lock    = '0;

        unique case (cur.prefix)
            PFX_IDLE: begin
                if (scan_byte == BYTE_E0) begin
                    nxt.prefix = PFX_E0;
                end else if (scan_byte == BYTE_E1) begin
                    nxt.prefix = PFX_E1A;
                end else if (c != 7'h00 && c <= CODE_MAX && c != CODE_HOLE) begin
                    id = {1'b0, c};
                end
            end
            PFX_E0: begin
                id         = ext_id(c);
                nxt.prefix = PFX_IDLE;
            end
            PFX_E1A: begin
                nxt.prefix = (c == CODE_CTRL || c == CODE_NUMLK) ? PFX_E1B : PFX_IDLE;
            end
            default: begin
                if (c == CODE_CTRL || c == CODE_NUMLK) begin
                    id = ID_PAUSE;
                end
                nxt.prefix = PFX_IDLE;
            end
        endcase

        // Apply modifier and lock keys only when a key id was recognized
        m = mod_bit(id);
        if (id != ID_NONE) begin
            nxt.mods = rel ? (cur.mods & ~m) : (cur.mods | m);
            if (id == ID_NUMLOCK) begin
                lock = LOCK_NUM;
            end else if (id == ID_CAPSLOCK) begin
                lock = LOCK_CAPS;
            end else if (id == ID_SCROLL) begin
                lock = LOCK_SCROLL;
            end
            if (lock != '0 && !rel) begin
                nxt.locks = cur.locks ^ lock;
                changed   = 1'b1;
            end
        end

        chord = (nxt.mods & MOD_CTRL_ANY) != '0 && (nxt.mods & MOD_ALT_ANY) != '0;
        f     = fkey_num(id);

        res.valid        = (id != ID_NONE);
        res.event_kind   = KIND_KEY;
        res.key_id       = id;
        res.released     = rel;
        res.modifiers    = nxt.mods;
        res.lock_leds    = nxt.locks;
        res.leds_changed = changed;
        res.action_value = ACT_NONE;

        if (chord && (id == ID_DELETE || id == ID_PADDELETE || f != ACT_NONE)) begin
            // Hold the release of a chord key back entirely
            res.valid        = (id != ID_NONE) && !rel;
            res.released     = 1'b0;
            res.leds_changed = 1'b0;
            if (id == ID_DELETE) begin
                res.event_kind   = KIND_REBOOT;
                res.action_value = ACT_DELETE;
            end else if (id == ID_PADDELETE) begin
                res.event_kind   = KIND_REBOOT;
                res.action_value = ACT_PADDEL;
            end else begin
                res.event_kind   = KIND_CONSOLE;
                res.action_value = f;
            end
        end
    end

endmodule

@@ verif/scan_set1_key_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the set-1 scan code decoder: directed and random scan streams.
module scan_set1_key_decoder_tb;
    import ss1kd_pkg::*;

    localparam int CycleLimit = 100_000;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] key_id;
        logic             released;
        logic [ModW-1:0]  mods;
        logic [LockW-1:0] leds;
        logic             leds_changed;
        logic [ActW-1:0]  action;
    } key_event_t;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [7:0]      s_tdata;    // [7:0] scan_byte
    logic            m_tvalid;
    logic            m_tready;
    logic [OutW-1:0] m_tdata;    // [1:0] event_kind, [9:2] key_id, [10] released,
                                 // [18:11] modifiers, [21:19] lock_leds,
                                 // [22] leds_changed, [26:23] action_value

    // Decoder state as predicted from the accepted bytes
    logic [PfxW-1:0]  prefix_track = PFX_IDLE;
    logic [ModW-1:0]  held_mods    = '0;
    logic [LockW-1:0] lock_leds_q  = LOCK_RESET;

    key_event_t  pending_events[$];
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          stall_left     = 0;

    scan_set1_key_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [ByteW-1:0] extended_key_id(input logic [6:0] code);
        case (code)
            7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D,
            7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C: return {1'b1, code};
            7'h37:   return 8'h54;
            7'h46:   return ID_PAUSE;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic logic [ModW-1:0] modifier_mask(input logic [ByteW-1:0] id);
        case (id)
            8'h1D:   return 8'h01;
            8'h2A:   return 8'h02;
            8'h38:   return 8'h04;
            8'hDB:   return 8'h08;
            8'h9D:   return 8'h10;
            8'h36:   return 8'h20;
            8'hB8:   return 8'h40;
            8'hDC:   return 8'h80;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [ActW-1:0] function_key_number(input logic [ByteW-1:0] id);
        logic [ByteW-1:0] offset;
        offset = id - 8'h3B;
        if (id >= 8'h3B && id <= 8'h44) return offset[ActW-1:0] + 4'd1;
        if (id == 8'h57) return 4'd11;
        if (id == 8'h58) return 4'd12;
        return ACT_NONE;
    endfunction

    // Apply one decoded key to modifiers and locks, queue its event unless a chord drops it
    task automatic apply_key(input logic [ByteW-1:0] id, input logic rel);
        logic [ModW-1:0]  m;
        logic [LockW-1:0] lk;
        logic [ActW-1:0]  fnum;
        key_event_t       ev;
        m = modifier_mask(id);
        if (m != '0) held_mods = rel ? (held_mods & ~m) : (held_mods | m);
        case (id)
            ID_NUMLOCK:  lk = LOCK_NUM;
            ID_CAPSLOCK: lk = LOCK_CAPS;
            ID_SCROLL:   lk = LOCK_SCROLL;
            default:     lk = '0;
        endcase
        ev.leds_changed = 1'b0;
        if (lk != '0 && !rel) begin
            lock_leds_q     = lock_leds_q ^ lk;
            ev.leds_changed = 1'b1;
        end
        ev.kind     = KIND_KEY;
        ev.key_id   = id;
        ev.released = rel;
        ev.mods     = held_mods;
        ev.leds     = lock_leds_q;
        ev.action   = ACT_NONE;
        if ((held_mods & MOD_CTRL_ANY) != '0 && (held_mods & MOD_ALT_ANY) != '0) begin
            fnum = function_key_number(id);
            if (id == ID_DELETE || id == ID_PADDELETE || fnum != ACT_NONE) begin
                // chord release: nothing comes out
                if (rel) return;
                ev.released     = 1'b0;
                ev.leds_changed = 1'b0;
                if (id == ID_DELETE) begin
                    ev.kind   = KIND_REBOOT;
                    ev.action = ACT_DELETE;
                end else if (id == ID_PADDELETE) begin
                    ev.kind   = KIND_REBOOT;
                    ev.action = ACT_PADDEL;
                end else begin
                    ev.kind   = KIND_CONSOLE;
                    ev.action = fnum;
                end
            end
        end
        pending_events.push_back(ev);
    endtask

    task automatic predict_scan(input logic [7:0] b);
        logic             rel;
        logic [6:0]       code;
        logic [ByteW-1:0] id;
        rel  = b[7];
        code = b[6:0];
        id   = ID_NONE;
        case (prefix_track)
            PFX_IDLE: begin
                if (b == BYTE_E0) prefix_track = PFX_E0;
                else if (b == BYTE_E1) prefix_track = PFX_E1A;
                else if (code >= 7'h01 && code <= CODE_MAX && code != CODE_HOLE)
                    id = {1'b0, code};
            end
            PFX_E0: begin
                id           = extended_key_id(code);
                prefix_track = PFX_IDLE;
            end
            PFX_E1A: begin
                prefix_track = (code == CODE_CTRL || code == CODE_NUMLK) ? PFX_E1B : PFX_IDLE;
            end
            default: begin
                if (code == CODE_CTRL || code == CODE_NUMLK) id = ID_PAUSE;
                prefix_track = PFX_IDLE;
            end
        endcase
        if (id != ID_NONE) apply_key(id, rel);
    endtask

    // Offer one byte, hold it until the transaction completes, then predict
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_scan(b);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Result receiver: random stalls plus an optional long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        key_event_t ev;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end else begin
                ev = pending_events.pop_front();
                check_field("event_kind",   32'(ev.kind),         32'(m_tdata[1:0]));
                check_field("key_id",       32'(ev.key_id),       32'(m_tdata[9:2]));
                check_field("released",     32'(ev.released),     32'(m_tdata[10]));
                check_field("modifiers",    32'(ev.mods),         32'(m_tdata[18:11]));
                check_field("lock_leds",    32'(ev.leds),         32'(m_tdata[21:19]));
                check_field("leds_changed", 32'(ev.leds_changed), 32'(m_tdata[22]));
                check_field("action_value", 32'(ev.action),       32'(m_tdata[26:23]));
            end
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [6:0] listed_ext_code(input int idx);
        case (idx)
            0:  return 7'h1C;
            1:  return 7'h1D;
            2:  return 7'h35;
            3:  return 7'h38;
            4:  return 7'h47;
            5:  return 7'h48;
            6:  return 7'h49;
            7:  return 7'h4B;
            8:  return 7'h4D;
            9:  return 7'h4F;
            10: return 7'h50;
            11: return 7'h51;
            12: return 7'h52;
            13: return 7'h53;
            14: return 7'h5B;
            15: return 7'h5C;
            16: return 7'h37;
            default: return 7'h46;
        endcase
    endfunction

    // Modifiers, locks, Delete and function keys get picked more often
    function automatic logic [6:0] hot_base_code(input int idx);
        case (idx)
            0:  return 7'h1D;
            1:  return 7'h2A;
            2:  return 7'h38;
            3:  return 7'h36;
            4:  return 7'h3A;
            5:  return 7'h45;
            6:  return 7'h46;
            7:  return 7'h53;
            8:  return 7'h3B;
            9:  return 7'h44;
            10: return 7'h57;
            11: return 7'h58;
            default: return 7'h01;
        endcase
    endfunction

    task automatic test_base_codes();
        send_byte(8'h01);   // lowest code, press
        send_byte(8'hD8);   // highest code, release
        send_byte(8'h00);   // unknown, dropped
        send_byte(8'h55);   // hole in the table, dropped
        send_byte(8'hFF);   // unknown release
        send_byte(8'h7F);
    endtask

    task automatic test_extended_codes();
        send_byte(BYTE_E0);
        send_byte(8'h37);   // print screen alias
        send_byte(BYTE_E0);
        send_byte(BYTE_E0); // prefix after prefix, dropped
        send_byte(BYTE_E0);
        send_byte(8'hC6);   // ctrl-break release
    endtask

    task automatic test_pause_sequences();
        send_byte(BYTE_E1);
        send_byte(8'h1D);
        send_byte(8'hC5);   // release flag comes from the final byte
        send_byte(BYTE_E1);
        send_byte(8'h9D);
        send_byte(8'h45);
        send_byte(BYTE_E1);
        send_byte(8'h00);   // broken right after the prefix
    endtask

    task automatic test_lock_keys();
        send_byte(8'h3A);
        send_byte(8'h45);
        send_byte(8'h46);
    endtask

    task automatic test_chords();
        send_byte(8'h1D);   // left ctrl
        send_byte(8'h38);   // left alt
        send_byte(BYTE_E0);
        send_byte(8'h53);   // delete: reboot
        send_byte(8'h53);   // keypad delete: reboot
        send_byte(8'h3B);   // F1: console switch
        send_byte(8'hD8);   // F12 release under chord, dropped
        send_byte(8'h9D);
        send_byte(8'hB8);
    endtask

    task automatic test_backpressure();
        stall_left = 150;
        for (int i = 0; i < 16; i++) send_byte(i[0] ? 8'h9E : 8'h1E);
    endtask

    task automatic test_random_strokes(input int strokes);
        int   pick;
        logic rel;
        for (int n = 0; n < strokes; n++) begin
            pick = $urandom_range(99);
            rel  = 1'($urandom_range(1));
            if (pick < 40) begin
                if ($urandom_range(3) == 0)
                    send_byte({rel, hot_base_code($urandom_range(12))});
                else
                    send_byte({rel, 7'($urandom_range(8'h58, 1))});
            end else if (pick < 60) begin
                send_byte(BYTE_E0);
                send_byte({rel, listed_ext_code($urandom_range(17))});
            end else if (pick < 70) begin
                send_byte(BYTE_E1);
                send_byte({1'($urandom_range(1)), $urandom_range(1) ? CODE_CTRL : CODE_NUMLK});
                send_byte({rel, $urandom_range(1) ? CODE_CTRL : CODE_NUMLK});
            end else if (pick < 82) begin
                // ctrl and alt down, then an action key
                if ($urandom_range(1)) send_byte(BYTE_E0);
                send_byte({1'b0, CODE_CTRL});
                if ($urandom_range(1)) send_byte(BYTE_E0);
                send_byte(8'h38);
                if ($urandom_range(2) == 0) begin
                    if ($urandom_range(1)) send_byte(BYTE_E0);
                    send_byte({rel, 7'h53});
                end else begin
                    send_byte({rel, hot_base_code($urandom_range(11, 8))});
                end
            end else if (pick < 92) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                // broken prefixes with random tails
                send_byte($urandom_range(1) ? BYTE_E0 : BYTE_E1);
                send_byte(8'($urandom_range(255)));
                if ($urandom_range(1)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 53;
        test_base_codes();
        test_extended_codes();
        test_pause_sequences();
        test_lock_keys();
        test_chords();
        test_backpressure();
        test_random_strokes(70);

        send_idle_pct = 53;
        recv_idle_pct = 33;
        test_random_strokes(70);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strokes(70);

        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
